>>> design/price_time_order_book_matcher_core_assert.svh
// Assertion macros for the order book matcher core.
// Every macro uses the clock and reset port names of the module that includes it.
`ifndef PRICE_TIME_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
`define PRICE_TIME_ORDER_BOOK_MATCHER_CORE_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define PTOB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PTOB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> design/ptob_pkg.sv
// Shared types and codes of the order book matcher.
// No dependencies; used by the cell, the book and the top level.
`timescale 1ns / 1ps
package ptob_pkg;

   localparam logic [2:0] ACT_LIMIT   = 3'd0;
   localparam logic [2:0] ACT_MARKET  = 3'd1;
   localparam logic [2:0] ACT_IOC     = 3'd2;
   localparam logic [2:0] ACT_FOK     = 3'd3;
   localparam logic [2:0] ACT_CANCEL  = 3'd4;
   localparam logic [2:0] ACT_REPLACE = 3'd5;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_KILLED    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic [24:0] SUM_CAP = 25'h1000000;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_POP,
      OP_DEC,
      OP_INSERT,
      OP_KILL,
      OP_COMPACT,
      OP_SHRINK
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_MATCH,
      S_INSERT,
      S_KILL,
      S_COMPACT,
      S_SHRINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [23:0] price;
      logic [23:0] qty;
      logic [31:0] id;
   } entry_type;

   typedef struct packed {
      logic [24:0] sum;
      logic        seen;
      logic        shr;
   } prefix_type;

   typedef struct packed {
      op_type      op;
      logic [23:0] price;
      logic [23:0] qty;
      logic [31:0] id;
      logic [23:0] dec;
   } cmd_type;

   typedef struct packed {
      entry_type  head;
      logic       full;
      prefix_type total;
   } book_stat_type;

endpackage

>>> design/price_time_order_book_matcher_core.sv
// Price-time priority order book matcher with a buy and a sell row of cells.
// Matching pops or decrements the head of the opposite row, one resting entry per step,
// then leaves the loop, inserts any limit remainder and gives the result.
// Fill-or-kill, cancel and replace first run a prefix sweep across all BOOK_DEPTH cells;
// a removal adds a kill step and a compaction pass. The receiver cannot stall.
// Synchronous reset empties both books at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "price_time_order_book_matcher_core_assert.svh"
module price_time_order_book_matcher_core
   import ptob_pkg::*;
#(
   parameter int BOOK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic        req_side,
   input  logic [31:0] req_order_id,
   input  logic [23:0] req_limit_price,
   input  logic [23:0] req_order_quantity,
   output logic        rsp_valid,
   output logic [47:0] rsp_traded_value,
   output logic [23:0] rsp_filled_quantity,
   output logic [23:0] rsp_rested_quantity,
   output logic [1:0]  rsp_status
);

   localparam int CW = $clog2(BOOK_DEPTH);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff;
   logic [2:0]    action_ff;
   logic          side_ff, sel_ask_ff, sel_ask_in;
   logic [31:0]   id_ff;
   logic [23:0]   px_ff, qty_ff, left_ff, filled_ff, rested_ff, rested_in;
   logic [47:0]   val_ff, prod_ff, prod_in;
   logic          prod_v_ff;
   logic [1:0]    status_ff, status_in;

   cmd_type       ask_cmd, bid_cmd;
   book_stat_type ask_stat, bid_stat, opp_stat;
   entry_type     head;
   logic          limited, crossing, go, pop, sweep_done, insert_own;
   logic [23:0]   fill, ins_qty;

   ptob_book #(.BOOK_DEPTH(BOOK_DEPTH), .IS_ASK(1'b1)) u_ask (
      .clock(clock), .reset(reset), .cmd(ask_cmd), .stat(ask_stat)
   );
   ptob_book #(.BOOK_DEPTH(BOOK_DEPTH), .IS_ASK(1'b0)) u_bid (
      .clock(clock), .reset(reset), .cmd(bid_cmd), .stat(bid_stat)
   );

   always_comb begin
      opp_stat   = side_ff ? bid_stat : ask_stat;
      head       = opp_stat.head;
      limited    = (action_ff != ACT_MARKET);
      crossing   = side_ff ? (head.price >= px_ff) : (head.price <= px_ff);
      go         = (left_ff != 24'd0) && head.valid && (!limited || crossing);
      fill       = (head.qty < left_ff) ? head.qty : left_ff;
      pop        = (fill == head.qty);
      prod_in    = 48'(head.price) * 48'(fill);
      sweep_done = (cnt_ff == CW'(BOOK_DEPTH - 1));
      ins_qty    = (action_ff == ACT_REPLACE) ? qty_ff : left_ff;
      insert_own = (action_ff == ACT_LIMIT) && (left_ff != 24'd0) &&
                   !(side_ff ? ask_stat.full : bid_stat.full);
   end

   always_comb begin
      state_in   = state_ff;
      sel_ask_in = sel_ask_ff;
      status_in  = status_ff;
      rested_in  = rested_ff;
      case (state_ff)
         S_IDLE: begin
            sel_ask_in = req_side;
            status_in  = ST_DONE;
            rested_in  = 24'd0;
            if (start) begin
               if (req_action == ACT_LIMIT || req_action == ACT_MARKET ||
                   req_action == ACT_IOC) begin
                  state_in = S_MATCH;
               end else if (req_action == ACT_FOK || req_action == ACT_CANCEL ||
                            req_action == ACT_REPLACE) begin
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SWEEP: begin
            if (sweep_done) begin
               if (action_ff == ACT_FOK) begin
                  if (opp_stat.total.sum >= {1'b0, qty_ff}) begin
                     state_in = S_MATCH;
                  end else begin
                     status_in = ST_KILLED;
                     state_in  = S_RESP;
                  end
               end else if (action_ff == ACT_CANCEL) begin
                  if (ask_stat.total.seen) begin
                     sel_ask_in = 1'b1;
                     state_in   = S_KILL;
                  end else if (bid_stat.total.seen) begin
                     sel_ask_in = 1'b0;
                     state_in   = S_KILL;
                  end else begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end else begin
                  if (bid_stat.total.seen) begin
                     sel_ask_in = 1'b0;
                     state_in   = bid_stat.total.shr ? S_SHRINK : S_KILL;
                  end else if (ask_stat.total.seen) begin
                     sel_ask_in = 1'b1;
                     state_in   = ask_stat.total.shr ? S_SHRINK : S_KILL;
                  end else begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_RESP;
                  end
               end
            end
         end
         S_MATCH: begin
            if (!go) begin
               if (insert_own) begin
                  rested_in = left_ff;
                  state_in  = S_INSERT;
               end else begin
                  if (action_ff == ACT_LIMIT && left_ff != 24'd0) begin
                     status_in = ST_FULL;
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_INSERT: begin
            state_in = S_RESP;
         end
         S_KILL: begin
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            if (sweep_done) begin
               if (action_ff == ACT_REPLACE && qty_ff != 24'd0) begin
                  rested_in = qty_ff;
                  state_in  = S_INSERT;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_SHRINK: begin
            rested_in = qty_ff;
            state_in  = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      ask_cmd.op    = OP_HOLD;
      ask_cmd.price = px_ff;
      ask_cmd.qty   = ins_qty;
      ask_cmd.id    = id_ff;
      ask_cmd.dec   = fill;
      bid_cmd       = ask_cmd;
      busy          = (state_ff != S_IDLE);
      rsp_valid     = (state_ff == S_RESP);
      case (state_ff)
         S_MATCH: begin
            if (go) begin
               if (side_ff) begin
                  bid_cmd.op = pop ? OP_POP : OP_DEC;
               end else begin
                  ask_cmd.op = pop ? OP_POP : OP_DEC;
               end
            end
         end
         S_INSERT: begin
            if (sel_ask_ff) begin
               ask_cmd.op = OP_INSERT;
            end else begin
               bid_cmd.op = OP_INSERT;
            end
         end
         S_KILL: begin
            if (sel_ask_ff) begin
               ask_cmd.op = OP_KILL;
            end else begin
               bid_cmd.op = OP_KILL;
            end
         end
         S_COMPACT: begin
            if (sel_ask_ff) begin
               ask_cmd.op = OP_COMPACT;
            end else begin
               bid_cmd.op = OP_COMPACT;
            end
         end
         S_SHRINK: begin
            if (sel_ask_ff) begin
               ask_cmd.op = OP_SHRINK;
            end else begin
               bid_cmd.op = OP_SHRINK;
            end
         end
         default: begin
            ask_cmd.op = OP_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      sel_ask_ff <= sel_ask_in;
      status_ff  <= status_in;
      rested_ff  <= rested_in;
      prod_ff    <= prod_in;
      if (state_ff == S_IDLE) begin
         action_ff <= req_action;
         side_ff   <= req_side;
         id_ff     <= req_order_id;
         px_ff     <= req_limit_price;
         qty_ff    <= req_order_quantity;
         left_ff   <= req_order_quantity;
         filled_ff <= 24'd0;
         val_ff    <= 48'd0;
      end else begin
         if (prod_v_ff) begin
            val_ff <= val_ff + prod_ff;
         end
         if (state_ff == S_MATCH && go) begin
            left_ff   <= left_ff - fill;
            filled_ff <= filled_ff + fill;
         end
      end
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         prod_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prod_v_ff <= (state_ff == S_MATCH) && go;
         if (state_ff != state_in) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_traded_value    = val_ff;
   assign rsp_filled_quantity = filled_ff;
   assign rsp_rested_quantity = rested_ff;
   assign rsp_status          = status_ff;

   `PTOB_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "result strobe held too long")
   `PTOB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted order did not go busy")
   `PTOB_ASSERT_SAME(a_fill_bound, state_ff == S_MATCH, filled_ff + left_ff == qty_ff,
      "filled and remaining quantity lost track")
   `PTOB_ASSERT_SAME(a_rest_status, rsp_valid && rsp_status != ST_DONE,
      rsp_rested_quantity == 24'd0, "rested quantity on a failed order")

endmodule

>>> design/ptob_cell.sv
// One slot of a sorted book: holds one resting entry and a running prefix.
// Depends on ptob_pkg; instantiated in a row by ptob_book.
`timescale 1ns / 1ps
module ptob_cell
   import ptob_pkg::*;
#(
   parameter bit IS_ASK  = 1'b0,
   parameter bit IS_HEAD = 1'b0
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  entry_type  left_entry,
   input  logic       left_at,
   input  logic       left_hole,
   input  prefix_type left_pre,
   input  entry_type  right_entry,
   output entry_type  entry,
   output logic       at_out,
   output prefix_type pre_out
);

   entry_type  entry_ff, entry_in;
   prefix_type pre_ff;
   logic       ahead, crosses_px, match, first, shr_here;
   logic [25:0] sum_wide;

   assign entry = entry_ff;

   always_comb begin
      ahead      = entry_ff.valid &&
                   (IS_ASK ? (cmd.price < entry_ff.price) : (cmd.price > entry_ff.price));
      at_out     = !entry_ff.valid || ahead;
      crosses_px = IS_ASK ? (entry_ff.price <= cmd.price) : (entry_ff.price >= cmd.price);
      match      = entry_ff.valid && (entry_ff.id == cmd.id);
      first      = match && !pre_ff.seen;
      shr_here   = first && (entry_ff.price == cmd.price) && (entry_ff.qty > cmd.qty) &&
                   (cmd.qty != 24'd0);
      sum_wide   = {1'b0, pre_ff.sum} +
                   ((entry_ff.valid && crosses_px) ? {2'b00, entry_ff.qty} : 26'd0);
      pre_out.sum  = (sum_wide >= {1'b0, SUM_CAP}) ? SUM_CAP : sum_wide[24:0];
      pre_out.seen = pre_ff.seen || match;
      pre_out.shr  = pre_ff.shr || shr_here;
   end

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_DEC: begin
            if (IS_HEAD) begin
               entry_in.qty = entry_ff.qty - cmd.dec;
            end
         end
         OP_INSERT: begin
            if (at_out) begin
               if (left_at) begin
                  entry_in = left_entry;
               end else begin
                  entry_in.valid = 1'b1;
                  entry_in.price = cmd.price;
                  entry_in.qty   = cmd.qty;
                  entry_in.id    = cmd.id;
               end
            end
         end
         OP_KILL: begin
            if (match) begin
               entry_in.valid = 1'b0;
            end
         end
         OP_COMPACT: begin
            if (!entry_ff.valid) begin
               entry_in = right_entry;
            end else if (left_hole) begin
               entry_in.valid = 1'b0;
            end
         end
         OP_SHRINK: begin
            if (shr_here) begin
               entry_in.qty = cmd.qty;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.price <= entry_in.price;
      entry_ff.qty   <= entry_in.qty;
      entry_ff.id    <= entry_in.id;
      pre_ff         <= left_pre;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

>>> design/ptob_book.sv
// One side of the order book: a row of ptob_cell slots, best entry at slot zero.
// Depends on ptob_pkg and ptob_cell.
`timescale 1ns / 1ps
module ptob_book
   import ptob_pkg::*;
#(
   parameter int BOOK_DEPTH = 64,
   parameter bit IS_ASK     = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output book_stat_type stat
);

   entry_type  entries [BOOK_DEPTH];
   logic       ats     [BOOK_DEPTH];
   prefix_type pres    [BOOK_DEPTH];

   for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
      entry_type  l_entry, r_entry;
      logic       l_at, l_hole;
      prefix_type l_pre;

      if (i == 0) begin : g_first
         assign l_entry = '0;
         assign l_at    = 1'b0;
         assign l_hole  = 1'b0;
         assign l_pre   = '0;
      end else begin : g_rest
         assign l_entry = entries[i-1];
         assign l_at    = ats[i-1];
         assign l_hole  = !entries[i-1].valid;
         assign l_pre   = pres[i-1];
      end

      if (i == BOOK_DEPTH - 1) begin : g_last
         assign r_entry = '0;
      end else begin : g_inner
         assign r_entry = entries[i+1];
      end

      ptob_cell #(
         .IS_ASK (IS_ASK),
         .IS_HEAD(i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_entry (l_entry),
         .left_at    (l_at),
         .left_hole  (l_hole),
         .left_pre   (l_pre),
         .right_entry(r_entry),
         .entry      (entries[i]),
         .at_out     (ats[i]),
         .pre_out    (pres[i])
      );
   end

   assign stat.head  = entries[0];
   assign stat.full  = entries[BOOK_DEPTH-1].valid;
   assign stat.total = pres[BOOK_DEPTH-1];

endmodule

>>> bench/price_time_order_book_matcher_core_test.sv
// Self-checking bench for the price-time order book matcher core.
// Depends on ptob_pkg and the matcher core; the books are modeled here with plain arrays.
`timescale 1ns / 1ps
module price_time_order_book_matcher_core_test;
   import ptob_pkg::*;

   localparam int DEPTH = 64;
   localparam logic SIDE_BUY = 1'b0;
   localparam logic SIDE_SELL = 1'b1;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      logic [47:0] value;
      logic [23:0] filled;
      logic [23:0] rested;
      logic [1:0]  status;
   } exec_report_t;

   typedef struct {
      bit           typed;
      logic [2:0]   action;
      logic         side;
      logic [31:0]  id;
      logic [23:0]  price;
      logic [23:0]  qty;
      exec_report_t report;
   } order_row_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_action;
   logic        req_side;
   logic [31:0] req_order_id;
   logic [23:0] req_limit_price;
   logic [23:0] req_order_quantity;
   logic        rsp_valid;
   logic [47:0] rsp_traded_value;
   logic [23:0] rsp_filled_quantity;
   logic [23:0] rsp_rested_quantity;
   logic [1:0]  rsp_status;

   // Index 0 is the buy book, index 1 the sell book.
   logic [23:0] book_px [2][DEPTH];
   logic [23:0] book_qty [2][DEPTH];
   logic [31:0] book_id [2][DEPTH];
   int          book_n [2];

   exec_report_t exec_reports[$];
   order_row_t   directed_rows[$];
   int           mismatch_count = 0;
   int           quiet_cycles = 0;
   int           idle_percent = 0;

   price_time_order_book_matcher_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_side(req_side), .req_order_id(req_order_id),
      .req_limit_price(req_limit_price), .req_order_quantity(req_order_quantity),
      .rsp_valid(rsp_valid), .rsp_traded_value(rsp_traded_value),
      .rsp_filled_quantity(rsp_filled_quantity),
      .rsp_rested_quantity(rsp_rested_quantity), .rsp_status(rsp_status)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic void book_remove_at(int b, int idx);
      for (int k = idx; k + 1 < book_n[b]; k++) begin
         book_px[b][k] = book_px[b][k + 1];
         book_qty[b][k] = book_qty[b][k + 1];
         book_id[b][k] = book_id[b][k + 1];
      end
      book_n[b]--;
   endfunction

   function automatic void book_insert(int b, logic [23:0] px, logic [23:0] qty,
                                       logic [31:0] id);
      int pos = 0;
      while (pos < book_n[b]) begin
         if (b == 1 ? (px < book_px[b][pos]) : (px > book_px[b][pos])) break;
         pos++;
      end
      for (int k = book_n[b]; k > pos; k--) begin
         book_px[b][k] = book_px[b][k - 1];
         book_qty[b][k] = book_qty[b][k - 1];
         book_id[b][k] = book_id[b][k - 1];
      end
      book_px[b][pos] = px;
      book_qty[b][pos] = qty;
      book_id[b][pos] = id;
      book_n[b]++;
   endfunction

   function automatic bit book_crosses(int b, int idx, bit limited, logic [23:0] px);
      if (!limited) return 1'b1;
      return (b == 1) ? (book_px[b][idx] <= px) : (book_px[b][idx] >= px);
   endfunction

   function automatic logic [23:0] book_sweep(int b, bit limited, logic [23:0] px,
                                              logic [23:0] qty, inout logic [47:0] value);
      logic [23:0] left = qty;
      logic [23:0] f;
      while (left != 0 && book_n[b] != 0 && book_crosses(b, 0, limited, px)) begin
         f = (book_qty[b][0] < left) ? book_qty[b][0] : left;
         value += 48'(book_px[b][0]) * 48'(f);
         left -= f;
         if (f == book_qty[b][0]) book_remove_at(b, 0);
         else book_qty[b][0] -= f;
      end
      return qty - left;
   endfunction

   function automatic bit book_remove_id(int b, logic [31:0] id);
      int w = 0;
      bit hit = 1'b0;
      for (int r = 0; r < book_n[b]; r++) begin
         if (book_id[b][r] == id) begin
            hit = 1'b1;
         end else begin
            book_px[b][w] = book_px[b][r];
            book_qty[b][w] = book_qty[b][r];
            book_id[b][w] = book_id[b][r];
            w++;
         end
      end
      book_n[b] = w;
      return hit;
   endfunction

   function automatic int book_find(int b, logic [31:0] id);
      for (int k = 0; k < book_n[b]; k++)
         if (book_id[b][k] == id) return k;
      return -1;
   endfunction

   function automatic exec_report_t book_execute(logic [2:0] action, logic side,
                                                 logic [31:0] id, logic [23:0] px,
                                                 logic [23:0] qty);
      exec_report_t rep = '{default: '0};
      int own = side;
      int opp = !side;
      int b;
      int idx;
      logic [24:0] avail = '0;
      rep.status = ST_DONE;
      case (action)
         ACT_LIMIT, ACT_MARKET, ACT_IOC: begin
            rep.filled = book_sweep(opp, action != ACT_MARKET, px, qty, rep.value);
            if (action == ACT_LIMIT && rep.filled < qty) begin
               if (book_n[own] >= DEPTH) begin
                  rep.status = ST_FULL;
               end else begin
                  rep.rested = qty - rep.filled;
                  book_insert(own, px, rep.rested, id);
               end
            end
         end
         ACT_FOK: begin
            for (int k = 0; k < book_n[opp] && avail < qty && book_crosses(opp, k, 1'b1, px);
                 k++)
               avail += book_qty[opp][k];
            if (avail >= qty) rep.filled = book_sweep(opp, 1'b1, px, qty, rep.value);
            else rep.status = ST_KILLED;
         end
         ACT_CANCEL: begin
            if (!book_remove_id(1, id) && !book_remove_id(0, id)) rep.status = ST_NOT_FOUND;
         end
         ACT_REPLACE: begin
            b = 0;
            idx = book_find(0, id);
            if (idx < 0) begin
               b = 1;
               idx = book_find(1, id);
            end
            if (idx < 0) begin
               rep.status = ST_NOT_FOUND;
            end else if (book_px[b][idx] == px && book_qty[b][idx] > qty && qty != 0) begin
               book_qty[b][idx] = qty;
               rep.rested = qty;
            end else begin
               void'(book_remove_id(b, id));
               if (qty != 0) begin
                  book_insert(b, px, qty, id);
                  rep.rested = qty;
               end
            end
         end
         default: ;
      endcase
      return rep;
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      exec_report_t want;
      if (!reset && ((start && !busy) || rsp_valid)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid) begin
         if (exec_reports.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_status, 0);
         end else begin
            want = exec_reports[0];
            exec_reports.delete(0);
            if (rsp_traded_value !== want.value)
               report_mismatch("traded_value", rsp_traded_value, want.value);
            if (rsp_filled_quantity !== want.filled)
               report_mismatch("filled_quantity", rsp_filled_quantity, want.filled);
            if (rsp_rested_quantity !== want.rested)
               report_mismatch("rested_quantity", rsp_rested_quantity, want.rested);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("price_time_order_book_matcher_core_test NOT OK");
         $finish;
      end
   end

   task automatic put_row(int typed, logic [2:0] action, logic side, int unsigned id,
                          int unsigned px, int unsigned qty, longint unsigned value,
                          int unsigned filled, int unsigned rested, int unsigned status);
      order_row_t row;
      row.typed = (typed != 0);
      row.action = action;
      row.side = side;
      row.id = id;
      row.price = 24'(px);
      row.qty = 24'(qty);
      row.report = '{48'(value), 24'(filled), 24'(rested), 2'(status)};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic send_order(order_row_t row);
      exec_report_t predicted;
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= row.action;
      req_side <= row.side;
      req_order_id <= row.id;
      req_limit_price <= row.price;
      req_order_quantity <= row.qty;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = book_execute(row.action, row.side, row.id, row.price, row.qty);
      exec_reports.insert(exec_reports.size(), row.typed ? row.report : predicted);
   endtask

   task automatic random_order(output order_row_t row);
      int pick = $urandom_range(99);
      row.typed = 1'b0;
      row.side = 1'($urandom_range(1));
      row.id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(15));
      row.price = ($urandom_range(19) == 0) ? 24'($urandom())
                                           : 24'(1000 + $urandom_range(16) - 8);
      case ($urandom_range(19))
         0: row.qty = 24'($urandom());
         1: row.qty = '0;
         default: row.qty = 24'($urandom_range(20, 1));
      endcase
      if (pick < 45) row.action = ACT_LIMIT;
      else if (pick < 53) row.action = ACT_MARKET;
      else if (pick < 63) row.action = ACT_IOC;
      else if (pick < 73) row.action = ACT_FOK;
      else if (pick < 86) row.action = ACT_CANCEL;
      else row.action = ACT_REPLACE;
   endtask

   initial begin
      order_row_t row;
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_LIMIT;
      req_side = SIDE_BUY;
      req_order_id = '0;
      req_limit_price = '0;
      req_order_quantity = '0;
      for (int b = 0; b < 2; b++) book_n[b] = 0;

      put_row(1, ACT_CANCEL, SIDE_SELL, 1, 0, 0, 0, 0, 0, ST_NOT_FOUND);
      put_row(1, ACT_REPLACE, SIDE_BUY, 1, 5, 5, 0, 0, 0, ST_NOT_FOUND);
      put_row(1, ACT_FOK, SIDE_BUY, 2, 100, 5, 0, 0, 0, ST_KILLED);
      put_row(1, ACT_FOK, SIDE_SELL, 2, 100, 0, 0, 0, 0, ST_DONE);
      put_row(1, ACT_LIMIT, SIDE_BUY, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              0, 0, 24'hFFFFFF, ST_DONE);
      put_row(1, ACT_LIMIT, SIDE_SELL, 3, 0, 1, 48'hFFFFFF, 1, 0, ST_DONE);
      put_row(1, ACT_MARKET, SIDE_SELL, 4, 0, 0, 0, 0, 0, ST_DONE);
      put_row(1, ACT_IOC, SIDE_SELL, 5, 0, 2, 48'h1FFFFFE, 2, 0, ST_DONE);
      put_row(1, ACT_CANCEL, SIDE_BUY, 32'hFFFFFFFF, 0, 0, 0, 0, 0, ST_DONE);
      put_row(0, ACT_LIMIT, SIDE_SELL, 10, 100, 10, 0, 0, 0, 0);
      put_row(0, ACT_LIMIT, SIDE_SELL, 11, 100, 5, 0, 0, 0, 0);
      put_row(0, ACT_LIMIT, SIDE_SELL, 12, 90, 3, 0, 0, 0, 0);
      put_row(1, ACT_FOK, SIDE_BUY, 13, 95, 4, 0, 0, 0, ST_KILLED);
      put_row(0, ACT_FOK, SIDE_BUY, 13, 100, 4, 0, 0, 0, 0);
      put_row(0, ACT_REPLACE, SIDE_BUY, 11, 100, 2, 0, 0, 0, 0);
      put_row(0, ACT_REPLACE, SIDE_SELL, 10, 80, 7, 0, 0, 0, 0);
      put_row(0, ACT_MARKET, SIDE_BUY, 14, 0, 100, 0, 0, 0, 0);
      put_row(0, ACT_LIMIT, SIDE_BUY, 20, 50, 5, 0, 0, 0, 0);
      put_row(0, ACT_LIMIT, SIDE_BUY, 20, 50, 6, 0, 0, 0, 0);
      put_row(0, ACT_CANCEL, SIDE_SELL, 20, 0, 0, 0, 0, 0, 0);
      put_row(1, ACT_REPLACE, SIDE_SELL, 99, 0, 0, 0, 0, 0, ST_NOT_FOUND);
      put_row(0, ACT_LIMIT, SIDE_BUY, 30, 60, 4, 0, 0, 0, 0);
      put_row(0, ACT_REPLACE, SIDE_BUY, 30, 60, 0, 0, 0, 0, 0);
      put_row(0, ACT_IOC, SIDE_BUY, 31, 10, 5, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_order(directed_rows[i]);

      for (int phase = 0; phase < 3; phase++) begin
         idle_percent = (phase == 0) ? 33 : (phase == 1) ? 56 : 0;
         if (phase == 0) begin
            // Deep resting bids, enough to hit the full-book rejection.
            for (int i = 0; i < DEPTH + 6; i++) begin
               row.typed = 1'b0;
               row.action = ACT_LIMIT;
               row.side = SIDE_BUY;
               row.id = 32'($urandom_range(40, 16));
               row.price = 24'($urandom_range(5, 1));
               row.qty = 24'($urandom_range(9, 1));
               send_order(row);
            end
         end
         for (int i = 0; i < 145; i++) begin
            random_order(row);
            send_order(row);
         end
      end
      start <= 1'b0;

      while (exec_reports.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) $display("price_time_order_book_matcher_core_test OK");
      else $display("price_time_order_book_matcher_core_test NOT OK");
      $finish;
   end

endmodule
